// ===== hw/rtl/rlsr_pkg.sv =====
package rlsr_pkg;

  localparam int unsigned DEPTH_DEF      = 256;
  localparam int unsigned VALUE_BITS_DEF = 32;

  typedef enum logic [1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_REMOVE  = 2'd1,
    FUNC_ADVANCE = 2'd2,
    FUNC_FIND    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PUSH = 2'd1,
    CELL_POP  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_FIND = 2'd1,
    ST_RESP = 2'd2
  } state_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] operand_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] head_value;
    logic               list_nonempty;
    logic [8:0]         entry_total;
    logic [1:0]         status;
    logic [7:0]         found_offset;
  } out_word_t;

endpackage

// ===== hw/rtl/ring_list_search_rotate_core.sv =====
// channel | dir | valid     | stall     | payload
// in      | in  | in_valid  | in_stall  | in_word  (func, operand_value)
// out     | out | out_valid | out_stall | out_word (head, count, status, offset)
// Insert, remove, advance: accept goes to RESP, which loads the result once out_free.
// Find: rotates until a match or the last entry, then RESP loads; 1 compare per cycle.
// Elements live in a row of cells, cell 0 is head; one shift/rotate per cycle.
// Reset clears count and control; cell contents are undefined until written.
// A stalled result holds; no new word is taken until the result is loaded.
module ring_list_search_rotate_core import rlsr_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         step_r, step_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;
  status_t               stat_r, stat_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_word_r, out_word_nxt;
  cell_op_t              cell_op;
  logic                  accept;
  logic                  out_free;
  logic [63:0]           op_ext;
  logic [VALUE_BITS-1:0] op_val;
  logic [63:0]           head_ext;
  logic [VALUE_BITS-1:0] q [DEPTH];

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign op_ext   = {{32{in_word.operand_value[31]}}, in_word.operand_value};
  assign op_val   = op_ext[VALUE_BITS-1:0];
  assign head_ext = 64'(signed'(q[0]));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_d;
    logic [VALUE_BITS-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = op_val;
    end else begin : g_mid
      assign left_d = q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = q[0];
    end else begin : g_inner
      assign right_d = q[i+1];
    end
    rlsr_cell #(
      .IDX(i), .DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk(clk), .op(cell_op), .count(count_r),
      .left_d(left_d), .right_d(right_d), .head_d(q[0]), .q(q[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_word.func == FUNC_FIND && count_r != '0) ? ST_FIND : ST_RESP;
        end
      end
      ST_FIND: begin
        if (q[0] == key_r || step_r == count_r - CW'(1)) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cell_op       = CELL_HOLD;
    count_nxt     = count_r;
    step_nxt      = step_r;
    key_nxt       = key_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          key_nxt  = op_val;
          step_nxt = '0;
          stat_nxt = STAT_OK;
          if (in_word.func == FUNC_INSERT) begin
            if (count_r == FULL_CNT) begin
              stat_nxt = STAT_FULL;
            end else begin
              cell_op   = CELL_PUSH;
              count_nxt = count_r + CW'(1);
            end
          end else if (count_r == '0) begin
            stat_nxt = STAT_EMPTY;
          end else if (in_word.func == FUNC_REMOVE) begin
            cell_op   = CELL_POP;
            count_nxt = count_r - CW'(1);
          end else if (in_word.func == FUNC_ADVANCE) begin
            cell_op = CELL_ROT;
          end
        end
      end
      ST_FIND: begin
        if (q[0] != key_r) begin
          cell_op = CELL_ROT;
          if (step_r == count_r - CW'(1)) begin
            stat_nxt = STAT_NOT_FOUND;
            step_nxt = '0;
          end else begin
            step_nxt = step_r + CW'(1);
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_word_nxt.head_value    = (count_r != '0) ? head_ext[31:0] : '0;
          out_word_nxt.list_nonempty = (count_r != '0);
          out_word_nxt.entry_total   = 9'(count_r);
          out_word_nxt.status        = stat_r;
          out_word_nxt.found_offset  = 8'(step_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    key_r      <= key_nxt;
    stat_r     <= stat_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT) else $error("count exceeds depth");

  a_find_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIND |-> count_r != '0) else $error("find on empty list");

  a_find_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIND |=> $stable(count_r)) else $error("count changed in find");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIND |-> step_r < count_r) else $error("find step overrun");

endmodule

// ===== hw/rtl/rlsr_cell.sv =====
module rlsr_cell import rlsr_pkg::*; #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  cell_op_t              op,
  input  logic [CW-1:0]         count,
  input  logic [VALUE_BITS-1:0] left_d,
  input  logic [VALUE_BITS-1:0] right_d,
  input  logic [VALUE_BITS-1:0] head_d,
  output logic [VALUE_BITS-1:0] q
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] val_nxt;
  logic                  is_tail;

  assign is_tail = (count == MY_IDX + CW'(1));

  always_comb begin
    unique case (op)
      CELL_HOLD: val_nxt = val_r;
      CELL_PUSH: val_nxt = left_d;
      CELL_POP:  val_nxt = right_d;
      CELL_ROT:  val_nxt = is_tail ? head_d : right_d;
      default:   val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign q = val_r;

endmodule
